### rtl/core/cbde_pkg.sv
// shared constants and helper functions for the cmos bcd date to epoch converter
`default_nettype none

package cbde_pkg;

  // field widths
  localparam int BYTE_W  = 8;
  localparam int YEAR_W  = 15;
  localparam int DAYS_W  = 25;
  localparam int TOD_W   = 20;
  localparam int EPOCH_W = 40;
  localparam int PROD_W  = 31;

  // calendar constants
  localparam logic [YEAR_W-1:0] BASE_YEAR      = 15'd1900;
  localparam logic [YEAR_W-1:0] Y2K_YEAR       = 15'd2000;
  localparam logic [BYTE_W-1:0] WINDOW_PIVOT   = 8'd70;
  localparam logic [BYTE_W-1:0] MONTHS_IN_YEAR = 8'd12;
  localparam logic [BYTE_W-1:0] FEBRUARY       = 8'd2;

  // reciprocals for division of values below 2**15 by 100 and by 400
  localparam logic [15:0] RECIP_100 = 16'd41944;
  localparam int          SHIFT_100 = 22;
  localparam logic [15:0] RECIP_400 = 16'd41944;
  localparam int          SHIFT_400 = 24;

  // high nibble times ten plus low nibble, no digit check
  function automatic logic [BYTE_W-1:0] bcd_val(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] hi;
    logic [BYTE_W-1:0] lo;
    hi = {4'b0000, b[7:4]};
    lo = {4'b0000, b[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

  // days in the months before the given one, common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

### rtl/core/cmos_bcd_date_to_epoch.sv
// top level: pipelined conversion of a cmos clock bcd snapshot to a signed epoch count
//
// A request is taken at each rising edge with start high and busy low. busy is
// always low, so a new snapshot can be presented in every cycle and the block
// sustains one request per clock.
// The result appears on epoch_seconds and range_error for exactly one cycle,
// marked by done. The five register stages (decode, reciprocal multiplies,
// day count, day to seconds multiply, final add) lie between the accepting
// edge and done. The receiver cannot stall, so nothing is held back.
// use_century is written through cfg_we and cfg_data; write it only while no
// request is in flight, as the block itself does not enforce this. It selects
// century*100+year over the 1970..2069 window.
// A year below 1900 or a month outside 1..12 gives range_error high and an
// epoch of zero.
// Synchronous reset clears the stage valid bits, done and use_century; any
// request in flight is dropped.
`default_nettype none

module cmos_bcd_date_to_epoch (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_data,
  input  wire logic [cbde_pkg::BYTE_W-1:0]       seconds_bcd,
  input  wire logic [cbde_pkg::BYTE_W-1:0]       minutes_bcd,
  input  wire logic [cbde_pkg::BYTE_W-1:0]       hours_bcd,
  input  wire logic [cbde_pkg::BYTE_W-1:0]       day_bcd,
  input  wire logic [cbde_pkg::BYTE_W-1:0]       month_bcd,
  input  wire logic [cbde_pkg::BYTE_W-1:0]       year_bcd,
  input  wire logic [cbde_pkg::BYTE_W-1:0]       century_bcd,
  output logic                                   done,
  output logic signed [cbde_pkg::EPOCH_W-1:0]    epoch_seconds,
  output logic                                   range_error
);

  localparam int BW = cbde_pkg::BYTE_W;
  localparam int YW = cbde_pkg::YEAR_W;
  localparam int DW = cbde_pkg::DAYS_W;
  localparam int TW = cbde_pkg::TOD_W;
  localparam int EW = cbde_pkg::EPOCH_W;
  localparam int PW = cbde_pkg::PROD_W;

  logic use_century;

  // stage 1 registers
  logic          s1_valid;
  logic [BW-1:0] s1_sec, s1_min, s1_hr, s1_day, s1_mon;
  logic [YW-1:0] s1_full, s1_ry;
  logic          s1_err;

  // stage 2 registers
  logic                 s2_valid;
  logic [BW-1:0]        s2_q100_full, s2_q100_ry, s2_day, s2_mon;
  logic [5:0]           s2_q400;
  logic signed [DW-1:0] s2_ry_days;
  logic signed [12:0]   s2_q4;
  logic [YW-1:0]        s2_full;
  logic [TW-1:0]        s2_tod;
  logic                 s2_err;

  // stage 3 registers
  logic                 s3_valid;
  logic signed [DW-1:0] s3_days;
  logic [TW-1:0]        s3_tod;
  logic                 s3_err;

  // stage 4 registers
  logic                 s4_valid;
  logic signed [EW-1:0] s4_prod;
  logic [TW-1:0]        s4_tod;
  logic                 s4_err;

  assign busy = 1'b0;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      use_century <= 1'b0;
    end else if (cfg_we) begin
      use_century <= cfg_data;
    end
  end

  // stage 1: bcd decode, full year and range check
  logic [BW-1:0] d_sec, d_min, d_hr, d_day, d_mon, d_yr, d_cent;
  logic [YW-1:0] d_full;
  logic          d_err;

  always_comb begin
    d_sec  = cbde_pkg::bcd_val(seconds_bcd);
    d_min  = cbde_pkg::bcd_val(minutes_bcd);
    d_hr   = cbde_pkg::bcd_val(hours_bcd);
    d_day  = cbde_pkg::bcd_val(day_bcd);
    d_mon  = cbde_pkg::bcd_val(month_bcd);
    d_yr   = cbde_pkg::bcd_val(year_bcd);
    d_cent = cbde_pkg::bcd_val(century_bcd);
    if (use_century) begin
      d_full = YW'(d_cent) * YW'(100) + YW'(d_yr);
    end else if (d_yr >= cbde_pkg::WINDOW_PIVOT) begin
      d_full = cbde_pkg::BASE_YEAR + YW'(d_yr);
    end else begin
      d_full = cbde_pkg::Y2K_YEAR + YW'(d_yr);
    end
    d_err = (d_full < cbde_pkg::BASE_YEAR) || (d_mon == '0) ||
            (d_mon > cbde_pkg::MONTHS_IN_YEAR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_sec  <= d_sec;
    s1_min  <= d_min;
    s1_hr   <= d_hr;
    s1_day  <= d_day;
    s1_mon  <= d_mon;
    s1_full <= d_full;
    s1_ry   <= d_full - cbde_pkg::BASE_YEAR;
    s1_err  <= d_err;
  end

  // stage 2: quotients by reciprocal, year days, leap count by four, time of day
  logic [PW-1:0]        p_full, p_ry100, p_ry400;
  logic [YW-1:0]        ry_m1, ry_p299;
  logic signed [DW-1:0] ry_off;
  logic signed [12:0]   q4;

  always_comb begin
    // truncation toward zero makes the first year's term zero
    ry_m1   = (s1_ry == '0) ? '0 : s1_ry - YW'(1);
    ry_p299 = s1_ry + YW'(299);
    p_full  = PW'(s1_full) * PW'(cbde_pkg::RECIP_100);
    p_ry100 = PW'(ry_m1) * PW'(cbde_pkg::RECIP_100);
    p_ry400 = PW'(ry_p299) * PW'(cbde_pkg::RECIP_400);
    ry_off  = $signed(DW'(s1_ry)) - $signed(DW'(70));
    // quarter rounds toward zero on both sides of the offset
    if (s1_ry >= YW'(69)) begin
      q4 = $signed(13'((s1_ry - YW'(69)) >> 2));
    end else begin
      q4 = -$signed(13'((YW'(69) - s1_ry) >> 2));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_q100_full <= BW'(p_full >> cbde_pkg::SHIFT_100);
    s2_q100_ry   <= BW'(p_ry100 >> cbde_pkg::SHIFT_100);
    s2_q400      <= 6'(p_ry400 >> cbde_pkg::SHIFT_400);
    s2_ry_days   <= ry_off * $signed(DW'(365));
    s2_q4        <= q4;
    s2_tod       <= TW'(s1_hr) * TW'(3600) + TW'(s1_min) * TW'(60) + TW'(s1_sec);
    s2_full      <= s1_full;
    s2_day       <= s1_day;
    s2_mon       <= s1_mon;
    s2_err       <= s1_err;
  end

  // stage 3: leap test, day of year and total day count
  logic [YW-1:0]        rem100;
  logic                 leap;
  logic signed [10:0]   yday;
  logic signed [DW-1:0] days;

  always_comb begin
    rem100 = s2_full - YW'(s2_q100_full) * YW'(100);
    leap   = (s2_full[1:0] == 2'b00) && ((rem100 != '0) || (s2_q100_full[1:0] == 2'b00));
    yday   = $signed(11'(cbde_pkg::days_before(s2_mon[3:0])))
           + $signed(11'((leap && (s2_mon > cbde_pkg::FEBRUARY)) ? 1 : 0))
           + $signed(11'(s2_day)) - $signed(11'(1));
    days   = s2_ry_days + $signed(DW'(s2_q400)) - $signed(DW'(s2_q100_ry))
           + DW'(s2_q4) + DW'(yday);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_days <= days;
    s3_tod  <= s2_tod;
    s3_err  <= s2_err;
  end

  // stage 4: days to seconds
  logic signed [EW-1:0] prod;

  assign prod = EW'(s3_days) * $signed(EW'(86400));

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_prod <= prod;
    s4_tod  <= s3_tod;
    s4_err  <= s3_err;
  end

  // stage 5: add time of day, zero the result on a range error
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    epoch_seconds <= s4_err ? '0 : s4_prod + $signed(EW'(s4_tod));
    range_error   <= s4_err;
  end

endmodule

`default_nettype wire

### sim/cbde_checker.sv
// checker for the bcd date to epoch converter: predicts each request and compares its result
module cbde_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic                                cfg_we,
  input  logic                                cfg_data,
  input  logic [cbde_pkg::BYTE_W-1:0]         seconds_bcd,
  input  logic [cbde_pkg::BYTE_W-1:0]         minutes_bcd,
  input  logic [cbde_pkg::BYTE_W-1:0]         hours_bcd,
  input  logic [cbde_pkg::BYTE_W-1:0]         day_bcd,
  input  logic [cbde_pkg::BYTE_W-1:0]         month_bcd,
  input  logic [cbde_pkg::BYTE_W-1:0]         year_bcd,
  input  logic [cbde_pkg::BYTE_W-1:0]         century_bcd,
  input  logic                                done,
  input  logic signed [cbde_pkg::EPOCH_W-1:0] epoch_seconds,
  input  logic                                range_error,
  output int                                  fail_count,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [cbde_pkg::EPOCH_W-1:0] epoch;
    logic                                range_error;
  } epoch_result_t;

  localparam longint SECS_DAY  = 86400;
  localparam longint SECS_YEAR = 31536000;
  localparam longint SECS_HOUR = 3600;

  epoch_result_t epoch_q[$];
  bit            century_en;

  // raw byte decode, no digit check
  function automatic longint bcd_decode(input logic [7:0] b);
    return longint'(b[7:4]) * 10 + longint'(b[3:0]);
  endfunction

  function automatic bit gregorian_leap(input longint y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // full calendar conversion with truncating division, as posix defines it
  function automatic epoch_result_t date_to_epoch(
    input logic [7:0] s_b, input logic [7:0] mi_b, input logic [7:0] h_b,
    input logic [7:0] d_b, input logic [7:0] mo_b, input logic [7:0] y_b,
    input logic [7:0] c_b, input bit cent
  );
    int            month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    longint        mon;
    longint        yr;
    longint        full;
    longint        yday;
    longint        ry;
    longint        total;
    epoch_result_t r;
    mon  = bcd_decode(mo_b);
    yr   = bcd_decode(y_b);
    yday = 0;
    if (cent) full = bcd_decode(c_b) * 100 + yr;
    else full = (yr >= 70) ? 1900 + yr : 2000 + yr;
    if (full < 1900 || mon < 1 || mon > 12) begin
      r.epoch       = '0;
      r.range_error = 1'b1;
      return r;
    end
    for (longint m = 1; m < mon; m++) begin
      if (m == 2 && gregorian_leap(full)) yday += 29;
      else yday += month_days[m-1];
    end
    yday += bcd_decode(d_b) - 1;
    ry = full - 1900;
    total = ((ry + 299) / 400) * SECS_DAY
          - ((ry - 1) / 100) * SECS_DAY
          + ((ry - 69) / 4) * SECS_DAY
          + (ry - 70) * SECS_YEAR
          + yday * SECS_DAY
          + bcd_decode(h_b) * SECS_HOUR
          + bcd_decode(mi_b) * 60
          + bcd_decode(s_b);
    r.epoch       = total[cbde_pkg::EPOCH_W-1:0];
    r.range_error = 1'b0;
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    century_en = 1'b0;
  end

  // results first, then new requests, then the register (it takes effect after this edge)
  always @(posedge clk) begin
    epoch_result_t want;
    if (rst) begin
      century_en = 1'b0;
      epoch_q.delete();
    end else begin
      if ($isunknown(done)) begin
        $error("done is unknown");
        fail_count++;
      end else if (done) begin
        if (epoch_q.size() == 0) begin
          $error("result with no request outstanding: epoch_seconds %0d range_error %0b",
                 epoch_seconds, range_error);
          fail_count++;
        end else begin
          want = epoch_q.pop_front();
          if (epoch_seconds !== want.epoch) begin
            $error("epoch_seconds mismatch: expected %0d, actual %0d",
                   want.epoch, epoch_seconds);
            fail_count++;
          end
          if (range_error !== want.range_error) begin
            $error("range_error mismatch: expected %0b, actual %0b",
                   want.range_error, range_error);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        epoch_q.push_back(date_to_epoch(seconds_bcd, minutes_bcd, hours_bcd, day_bcd,
                                        month_bcd, year_bcd, century_bcd, century_en));
      if (cfg_we) century_en = cfg_data;
    end
    pending = epoch_q.size();
  end

endmodule

### sim/tb_cmos_bcd_date_to_epoch.sv
// testbench top for the bcd date to epoch converter: clock, reset, requests and verdict
module tb_cmos_bcd_date_to_epoch;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  LATENCY     = 5;
  localparam int  CYCLE_LIMIT = 200000;
  localparam int  RAND_ITEMS  = 400;

  logic                                clk;
  logic                                rst;
  logic                                start;
  logic                                busy;
  logic                                cfg_we;
  logic                                cfg_data;
  logic [cbde_pkg::BYTE_W-1:0]         seconds_bcd;
  logic [cbde_pkg::BYTE_W-1:0]         minutes_bcd;
  logic [cbde_pkg::BYTE_W-1:0]         hours_bcd;
  logic [cbde_pkg::BYTE_W-1:0]         day_bcd;
  logic [cbde_pkg::BYTE_W-1:0]         month_bcd;
  logic [cbde_pkg::BYTE_W-1:0]         year_bcd;
  logic [cbde_pkg::BYTE_W-1:0]         century_bcd;
  logic                                done;
  logic signed [cbde_pkg::EPOCH_W-1:0] epoch_seconds;
  logic                                range_error;
  int                                  fail_count;
  int                                  pending;
  int                                  cycle_count;
  bit                                  gaps_off;

  cmos_bcd_date_to_epoch u_top (.*);

  cbde_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [7:0] to_bcd(input int v);
    return 8'((v / 10) * 16 + (v % 10));
  endfunction

  // present one request and hold it until taken
  task automatic send(input logic [7:0] s_b, input logic [7:0] mi_b, input logic [7:0] h_b,
                      input logic [7:0] d_b, input logic [7:0] mo_b, input logic [7:0] y_b,
                      input logic [7:0] c_b);
    @(negedge clk);
    start       <= 1'b1;
    seconds_bcd <= s_b;
    minutes_bcd <= mi_b;
    hours_bcd   <= h_b;
    day_bcd     <= d_b;
    month_bcd   <= mo_b;
    year_bcd    <= y_b;
    century_bcd <= c_b;
    do @(posedge clk); while (busy);
  endtask

  // random idle time between requests, mostly short
  task automatic idle_gap();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (gaps_off || pick < 50) n = 0;
    else if (pick < 85) n = $urandom_range(1, 3);
    else if (pick < 97) n = $urandom_range(4, 10);
    else n = $urandom_range(20, 40);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_century(input bit v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // mostly well-formed bcd dates, the rest raw noise
  task automatic send_random();
    if ($urandom_range(0, 99) < 75)
      send(to_bcd($urandom_range(0, 59)), to_bcd($urandom_range(0, 59)),
           to_bcd($urandom_range(0, 23)), to_bcd($urandom_range(1, 31)),
           to_bcd($urandom_range(1, 12)), to_bcd($urandom_range(0, 99)),
           to_bcd($urandom_range(18, 25)));
    else
      send(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
           8'($urandom), 8'($urandom), 8'($urandom));
    idle_gap();
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    cfg_we      = 1'b0;
    cfg_data    = 1'b0;
    seconds_bcd = '0;
    minutes_bcd = '0;
    hours_bcd   = '0;
    day_bcd     = '0;
    month_bcd   = '0;
    year_bcd    = '0;
    century_bcd = '0;
    gaps_off    = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // two-digit year window
    write_century(1'b0);
    send(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70, 8'h00); idle_gap();  // epoch start
    send(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h69, 8'h00); idle_gap();  // top of window
    send(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00, 8'h00); idle_gap();  // leap day
    send(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h99, 8'h00); idle_gap();
    send(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00); idle_gap();  // month zero
    send(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF); idle_gap();  // all ones
    send(8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h50, 8'h00); idle_gap();  // month thirteen
    send(8'h30, 8'h30, 8'h12, 8'h15, 8'h0A, 8'hA0, 8'h00); idle_gap();  // non-bcd nibbles
    send(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h70, 8'h55); idle_gap();  // day zero
    send(8'h00, 8'h00, 8'h00, 8'h01, 8'h12, 8'hF9, 8'h00); idle_gap();

    // century byte in use
    write_century(1'b1);
    send(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'h19); idle_gap();  // most negative
    send(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h18); idle_gap();  // year too early
    send(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00, 8'h20); idle_gap();
    send(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h21); idle_gap();  // century not leap
    send(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h24); idle_gap();  // 400-year leap
    send(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0C, 8'hFF, 8'hFF); idle_gap();  // largest epoch
    send(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'h00); idle_gap();  // year zero

    // random phases, alternating the year source
    for (int ph = 0; ph < 4; ph++) begin
      write_century(ph[0] == 1'b0);
      for (int i = 0; i < RAND_ITEMS / 4; i++) begin
        if (i % 25 == 0) gaps_off = ($urandom_range(0, 3) == 0);
        if (i == RAND_ITEMS / 8) drain();
        send_random();
      end
    end
    gaps_off = 1'b0;

    // let the pipeline empty
    drain();
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
